// ----- rtl/core/led_panel_grid_pixel_remap_macros.svh -----
// Assertion macros shared by the pixel remap RTL.
`ifndef LED_PANEL_GRID_PIXEL_REMAP_MACROS_SVH
`define LED_PANEL_GRID_PIXEL_REMAP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define LPGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define LPGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPGR_ASSERT_IMP(lbl, ante, cons, msg)
`define LPGR_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/core/lpgr_pkg.sv -----
// Package with the constants, codes and payload types of the pixel remap core.
package lpgr_pkg;

  // Default panel geometry and grid shape.
  localparam int PANEL_W_DEF   = 32;
  localparam int PANEL_H_DEF   = 32;
  localparam int GRID_COLS_DEF = 2;
  localparam int GRID_ROWS_DEF = 2;

  // Panel register file and written-pixel map.
  localparam int NUM_PANELS = 4;
  localparam int PIDX_W     = 2;
  localparam int POS_W      = 6;
  localparam int MAP_AW     = 2 * POS_W;
  localparam int MAP_DEPTH  = 1 << MAP_AW;

  // Bus widths.
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_W-1:0] REG_CUTOFF    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CHAIN_LEN = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PANEL_0   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PANEL_1   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_PANEL_2   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_PANEL_3   = 3'd5;

  // Item kinds carried on in_tuser.
  localparam logic FUNC_DRAW  = 1'b0;
  localparam logic FUNC_SWEEP = 1'b1;

  // Quarter-turn codes of a panel register.
  localparam logic [1:0] TURN_0   = 2'd0;
  localparam logic [1:0] TURN_90  = 2'd1;
  localparam logic [1:0] TURN_180 = 2'd2;
  localparam logic [1:0] TURN_270 = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [7:0] CUTOFF_RST    = 8'd0;
  localparam logic [3:0] CHAIN_LEN_RST = 4'd1;

  // One accepted input item.
  typedef struct packed {
    logic             func;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic             force_req;
  } pix_item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] out_x;
    logic [6:0] out_y;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } pix_result_t;

endpackage

// ----- rtl/core/led_panel_grid_pixel_remap.sv -----
// Top level of the LED panel grid pixel remap core.
//
// Channel   Direction  Transfer when             Payload
// in_       slave      in_tvalid & in_tready     tuser func, tdata pixel and colour
// out_      master     out_tvalid & out_tready   tdata canvas position and colour
// cfg_      write      cfg_we                    cfg_addr register, cfg_wdata value
//
// One item is accepted per clock unless input stops; its result (if any) is computed
// in the working stage and offered from the output register. The written map is a
// 4096 x 1 memory read when an item is accepted and written as the item leaves the
// working stage; a back-to-back hit on the same pixel is forwarded. After reset a
// clearing pass zeroes the map; no item is accepted then. A stalled output holds the
// item in the working stage; apart from the clearing pass, input stops only then.
`include "led_panel_grid_pixel_remap_macros.svh"

module led_panel_grid_pixel_remap #(
  parameter int PANEL_W   = lpgr_pkg::PANEL_W_DEF,
  parameter int PANEL_H   = lpgr_pkg::PANEL_H_DEF,
  parameter int GRID_COLS = lpgr_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = lpgr_pkg::GRID_ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream.
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_tdata: pos_x[5:0], pos_y[11:6], red[19:12], green[27:20], blue[35:28],
  // force_req[36], zero[39:37]
  input  logic [lpgr_pkg::IN_TDATA_W-1:0]     in_tdata,
  // in_tuser: func[0]
  input  logic                                in_tuser,
  // Result stream.
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_tdata: out_x[7:0], out_y[14:8], out_red[22:15], out_green[30:23],
  // out_blue[38:31], zero[39]
  output logic [lpgr_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Configuration write port.
  input  logic                                cfg_we,
  input  logic [lpgr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [lpgr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  import lpgr_pkg::*;

  localparam logic [8:0] X_LIMIT = 9'(GRID_COLS * PANEL_W);
  localparam logic [8:0] Y_LIMIT = 9'(GRID_ROWS * PANEL_H);
  localparam bit         SQUARE  = (PANEL_W == PANEL_H);
  localparam logic [POS_W-1:0] PW_MAX = POS_W'(PANEL_W - 1);
  localparam logic [POS_W-1:0] PH_MAX = POS_W'(PANEL_H - 1);

  // Configuration registers.
  logic [7:0]  cutoff_r;
  logic [3:0]  chain_len_r;
  logic [6:0]  panel_r [NUM_PANELS];

  // Clearing pass, working stage, output register.
  logic [MAP_AW:0]     clr_cnt_r;
  logic                clearing;
  logic                s1_v_r;
  pix_item_t           s1_item_r;
  logic                mark_r;
  logic                out_v_r;
  pix_result_t         out_res_r;

  // Written map.
  logic                map_mem [MAP_DEPTH];
  logic                map_we;
  logic [MAP_AW-1:0]   map_waddr;
  logic                map_wdata;

  pix_item_t           in_item;
  logic [MAP_AW-1:0]   in_addr;
  logic [MAP_AW-1:0]   s1_addr;
  logic                in_accept;
  logic                s1_adv;

  // Working-stage decode.
  logic [1:0]          col;
  logic [1:0]          row;
  logic [8:0]          lx_full;
  logic [8:0]          ly_full;
  logic [POS_W-1:0]    lx;
  logic [POS_W-1:0]    ly;
  logic [POS_W-1:0]    lx_rot;
  logic [POS_W-1:0]    ly_rot;
  logic [3:0]          pidx;
  logic                in_range;
  logic [6:0]          panel;
  logic [1:0]          turns;
  logic [2:0]          order;
  logic [1:0]          par;
  logic [3:0]          chain_pos;
  logic [7:0]          xoff;
  logic                dark;
  logic                s1_we;
  logic                s1_wdata;
  logic                s1_emit;
  pix_result_t         s1_res;

  // Unpack the input bus.
  assign in_item.func      = in_tuser;
  assign in_item.pos_x     = in_tdata[5:0];
  assign in_item.pos_y     = in_tdata[11:6];
  assign in_item.red       = in_tdata[19:12];
  assign in_item.green     = in_tdata[27:20];
  assign in_item.blue      = in_tdata[35:28];
  assign in_item.force_req = in_tdata[36];

  assign in_addr = {in_item.pos_x, in_item.pos_y};
  assign s1_addr = {s1_item_r.pos_x, s1_item_r.pos_y};

  // Handshake: the working stage moves on when the output register is free or drained.
  assign clearing  = ~clr_cnt_r[MAP_AW];
  assign s1_adv    = s1_v_r & (~out_v_r | out_tready);
  assign in_tready = ~clearing & (~s1_v_r | s1_adv);
  assign in_accept = in_tvalid & in_tready;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r    <= CUTOFF_RST;
      chain_len_r <= CHAIN_LEN_RST;
      for (int i = 0; i < NUM_PANELS; i++) begin
        panel_r[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_addr) inside
        REG_CUTOFF:    cutoff_r    <= cfg_wdata;
        REG_CHAIN_LEN: chain_len_r <= cfg_wdata[3:0];
        [REG_PANEL_0:REG_PANEL_3]: begin
          panel_r[PIDX_W'(cfg_addr - REG_PANEL_0)] <= cfg_wdata[6:0];
        end
        default: ;
      endcase
    end
  end

  // Clearing pass counter: runs once through the map after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (clearing) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // Map write port: the clearing pass, or the working stage as it moves on.
  assign map_we    = clearing | (s1_adv & s1_we);
  assign map_waddr = clearing ? clr_cnt_r[MAP_AW-1:0] : s1_addr;
  assign map_wdata = clearing ? 1'b0 : s1_wdata;

  // Map memory with a registered read; a write to the same pixel in the same cycle
  // is forwarded so that back-to-back items see each other's mark.
  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (in_accept) begin
      if (s1_adv && s1_we && (s1_addr == in_addr)) begin
        mark_r <= s1_wdata;
      end else begin
        mark_r <= map_mem[in_addr];
      end
    end
  end

  // Working stage: valid flag and captured item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_item;
    end
  end

  // Locate the panel: column and row by comparing against panel boundaries.
  always_comb begin
    col = '0;
    row = '0;
    for (int k = 1; k < GRID_COLS; k++) begin
      if ({3'b000, s1_item_r.pos_x} >= 9'(k * PANEL_W)) begin
        col = 2'(k);
      end
    end
    for (int k = 1; k < GRID_ROWS; k++) begin
      if ({3'b000, s1_item_r.pos_y} >= 9'(k * PANEL_H)) begin
        row = 2'(k);
      end
    end
    lx_full = {3'b000, s1_item_r.pos_x} - 9'(col * PANEL_W);
    ly_full = {3'b000, s1_item_r.pos_y} - 9'(row * PANEL_H);
    lx      = lx_full[POS_W-1:0];
    ly      = ly_full[POS_W-1:0];
    pidx    = 4'(row * GRID_COLS) + {2'b00, col};
  end

  // Pixels off the display or beyond the panel registers are ignored.
  assign in_range = ({3'b000, s1_item_r.pos_x} < X_LIMIT) &&
                    ({3'b000, s1_item_r.pos_y} < Y_LIMIT) &&
                    (pidx < 4'(NUM_PANELS));

  assign panel = panel_r[pidx[PIDX_W-1:0]];
  assign turns = panel[1:0];
  assign order = panel[4:2];
  assign par   = panel[6:5];

  // Rotation inside the panel; quarter turns act as no turn on a non-square panel.
  always_comb begin
    lx_rot = lx;
    ly_rot = ly;
    case (turns)
      TURN_90: begin
        if (SQUARE) begin
          lx_rot = PH_MAX - ly;
          ly_rot = lx;
        end
      end
      TURN_180: begin
        lx_rot = PW_MAX - lx;
        ly_rot = PH_MAX - ly;
      end
      TURN_270: begin
        if (SQUARE) begin
          lx_rot = ly;
          ly_rot = PW_MAX - lx;
        end
      end
      default: ;
    endcase
  end

  // Reversed chain position; an order past the end of the chain gives no offset.
  always_comb begin
    chain_pos = '0;
    if ((chain_len_r != 4'd0) && ({1'b0, order} < chain_len_r)) begin
      chain_pos = chain_len_r - 4'd1 - {1'b0, order};
    end
    xoff = 8'(chain_pos * PANEL_W);
  end

  // Cutoff test, written-map update and result decision.
  always_comb begin
    dark     = (s1_item_r.red < cutoff_r) && (s1_item_r.green < cutoff_r) &&
               (s1_item_r.blue < cutoff_r);
    s1_we    = 1'b0;
    s1_wdata = 1'b0;
    s1_emit  = 1'b0;
    if (in_range) begin
      if (s1_item_r.func == FUNC_SWEEP) begin
        // A sweep always clears the mark; an unmarked pixel gets a black write when the cutoff is zero.
        s1_we   = 1'b1;
        s1_emit = ~mark_r & (cutoff_r == 8'd0);
      end else begin
        s1_we    = ~dark & (~mark_r | s1_item_r.force_req);
        s1_wdata = 1'b1;
        s1_emit  = s1_we;
      end
    end
    s1_res.out_x     = xoff + {2'b00, lx_rot};
    s1_res.out_y     = 7'(par * PANEL_H) + {1'b0, ly_rot};
    s1_res.out_red   = (s1_item_r.func == FUNC_SWEEP) ? 8'd0 : s1_item_r.red;
    s1_res.out_green = (s1_item_r.func == FUNC_SWEEP) ? 8'd0 : s1_item_r.green;
    s1_res.out_blue  = (s1_item_r.func == FUNC_SWEEP) ? 8'd0 : s1_item_r.blue;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_adv) begin
      out_v_r <= s1_emit;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_res_r <= s1_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_res_r.out_blue, out_res_r.out_green, out_res_r.out_red,
                       out_res_r.out_y, out_res_r.out_x};

  // Checks on the pipeline and the clearing pass.
  `LPGR_ASSERT_IMP(a_no_accept_clearing, in_accept, !clearing, "item accepted while clearing")
  `LPGR_ASSERT_IMP(a_empty_clearing, clearing, !s1_v_r && !out_v_r, "pipeline busy while clearing")
  `LPGR_ASSERT_NXT(a_s1_hold, s1_v_r && !s1_adv, s1_v_r && $stable(s1_addr), "stalled item lost")

endmodule

// ----- tb/led_panel_grid_pixel_remap_checker.sv -----
// Checker that predicts the canvas writes of the pixel remap core and compares them.
`timescale 1ns / 1ps

module led_panel_grid_pixel_remap_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  // in_tdata: pos_x, pos_y, red, green, blue, force_req, zero padding
  input  logic [lpgr_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: func
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata: out_x, out_y, out_red, out_green, out_blue, zero padding
  input  logic [lpgr_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_we,
  input  logic [lpgr_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [lpgr_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                               pending,
  output int                               fail_count
);

  import lpgr_pkg::*;

  localparam int PW = PANEL_W_DEF;
  localparam int PH = PANEL_H_DEF;

  // Shadow copy of the registers and of the written-pixel map.
  logic [7:0]  cutoff_q;
  logic [3:0]  chain_len_q;
  logic [6:0]  panel_q [NUM_PANELS];
  logic        written_q [MAP_DEPTH];
  pix_result_t canvas_writes_q [$];

  // A pixel is too dark when every colour lies strictly below the cutoff.
  function automatic logic too_dark(input logic [7:0] r, input logic [7:0] g,
                                    input logic [7:0] b);
    return (r < cutoff_q) && (g < cutoff_q) && (b < cutoff_q);
  endfunction

  // Position on the chained canvas after the panel's rotation and chain offsets.
  function automatic pix_result_t place_on_canvas(input logic [5:0] x, input logic [5:0] y,
                                                  input logic [7:0] r, input logic [7:0] g,
                                                  input logic [7:0] b);
    int unsigned xi, yi, pidx, lx, ly, t, xoff, cl, order, par;
    logic [1:0]  turns;
    pix_result_t res;
    xi    = x;
    yi    = y;
    pidx  = GRID_COLS_DEF * (yi / PH) + xi / PW;
    turns = panel_q[pidx % NUM_PANELS][1:0];
    order = panel_q[pidx % NUM_PANELS][4:2];
    par   = panel_q[pidx % NUM_PANELS][6:5];
    lx    = xi % PW;
    ly    = yi % PH;
    // Quarter turns of 90 and 270 only apply to square panels.
    case (turns)
      TURN_90: if (PW == PH) begin
        t  = lx;
        lx = (PH - 1) - ly;
        ly = t;
      end
      TURN_180: begin
        lx = (PW - 1) - lx;
        ly = (PH - 1) - ly;
      end
      TURN_270: if (PW == PH) begin
        t  = ly;
        ly = (PW - 1) - lx;
        lx = t;
      end
      default: ;
    endcase
    // Chain order counts from the far end; an order past the chain gets no offset.
    cl   = chain_len_q;
    xoff = (cl >= 1 && order <= cl - 1) ? (cl - 1 - order) * PW : 0;
    res.out_x     = 8'(xoff + lx);
    res.out_y     = 7'(par * PH + ly);
    res.out_red   = r;
    res.out_green = g;
    res.out_blue  = b;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, actual %0d", name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    logic [5:0]  x, y;
    logic [7:0]  r, g, b;
    logic        frc;
    logic [11:0] addr;
    pix_result_t want;
    if (!rst_n) begin
      cutoff_q    = CUTOFF_RST;
      chain_len_q = CHAIN_LEN_RST;
      for (int i = 0; i < NUM_PANELS; i++) panel_q[i] = '0;
      for (int i = 0; i < MAP_DEPTH; i++) written_q[i] = 1'b0;
      canvas_writes_q.delete();
    end else begin
      // Compare a canvas write first: it always belongs to an earlier transfer.
      if (out_tvalid && out_tready) begin
        if (canvas_writes_q.size() == 0) begin
          $error("canvas write with none expected: x %0d y %0d", out_tdata[7:0],
                 out_tdata[14:8]);
          fail_count++;
        end else begin
          want = canvas_writes_q.pop_front();
          check_field("out_x", want.out_x, out_tdata[7:0]);
          check_field("out_y", 8'(want.out_y), 8'(out_tdata[14:8]));
          check_field("out_red", want.out_red, out_tdata[22:15]);
          check_field("out_green", want.out_green, out_tdata[30:23]);
          check_field("out_blue", want.out_blue, out_tdata[38:31]);
          check_field("padding", 8'd0, 8'(out_tdata[39]));
        end
      end

      // Register writes.
      if (cfg_we) begin
        case (cfg_addr)
          REG_CUTOFF:    cutoff_q    = cfg_wdata[7:0];
          REG_CHAIN_LEN: chain_len_q = cfg_wdata[3:0];
          REG_PANEL_0:   panel_q[0]  = cfg_wdata[6:0];
          REG_PANEL_1:   panel_q[1]  = cfg_wdata[6:0];
          REG_PANEL_2:   panel_q[2]  = cfg_wdata[6:0];
          REG_PANEL_3:   panel_q[3]  = cfg_wdata[6:0];
          default: ;
        endcase
      end

      // Every position on the 6-bit fields lies on the display with this grid,
      // so no item is ignored as off the display.
      if (in_tvalid && in_tready) begin
        x    = in_tdata[5:0];
        y    = in_tdata[11:6];
        r    = in_tdata[19:12];
        g    = in_tdata[27:20];
        b    = in_tdata[35:28];
        frc  = in_tdata[36];
        addr = {x, y};
        if (in_tuser == FUNC_DRAW) begin
          if (!too_dark(r, g, b) && (!written_q[addr] || frc)) begin
            written_q[addr] = 1'b1;
            canvas_writes_q.push_back(place_on_canvas(x, y, r, g, b));
          end
        end else begin
          // A sweep blanks an unwritten pixel and always clears the mark.
          if (!written_q[addr] && !too_dark(8'd0, 8'd0, 8'd0))
            canvas_writes_q.push_back(place_on_canvas(x, y, 8'd0, 8'd0, 8'd0));
          written_q[addr] = 1'b0;
        end
      end
    end
    pending = canvas_writes_q.size();
  end

endmodule

// ----- tb/led_panel_grid_pixel_remap_tb.sv -----
// Top of the pixel remap testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module led_panel_grid_pixel_remap_tb;
  import lpgr_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  // in_tdata: pos_x[5:0], pos_y[11:6], red[19:12], green[27:20], blue[35:28],
  // force_req[36], zero[39:37]
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  // in_tuser: func[0]
  logic                   in_tuser   = FUNC_DRAW;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata: out_x[7:0], out_y[14:8], out_red[22:15], out_green[30:23],
  // out_blue[38:31], zero[39]
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int          pending;
  int          fail_count;
  int          idle_cycles = 0;
  int          pixels_sent = 0;
  logic        send_steady = 1'b0;
  logic [7:0]  cur_cutoff  = CUTOFF_RST;
  logic [11:0] hot_pixels [8];

  led_panel_grid_pixel_remap uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  led_panel_grid_pixel_remap_checker canvas_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: ends the run once no transfer or register write has happened for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("led_panel_grid_pixel_remap_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: a random stall before each transfer, runs without stalls, and two
  // long hold-offs that let the core fill up and stall its input.
  initial begin : canvas_sink
    int   gap;
    int   taken;
    logic steady;
    taken  = 0;
    steady = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (taken % 40 == 0) steady = ($urandom_range(0, 2) == 0);
      gap = steady ? 0 : $urandom_range(0, 16);
      if (taken == 150 || taken == 450) gap = HOLD_CYCLES;
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken++;
      @(negedge clk);
    end
  end

  // Offers one pixel item after a random gap and returns once it is transferred.
  task automatic send_pixel(input logic func, input logic [5:0] x, input logic [5:0] y,
                            input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic frc);
    int gap;
    if (pixels_sent % 32 == 0) send_steady = ($urandom_range(0, 2) == 0);
    gap = send_steady ? 0 : $urandom_range(0, 16);
    pixels_sent++;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = func;
    in_tdata  = {3'b000, frc, b, g, r, y, x};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Waits until every expected canvas write has arrived and the pipeline is empty.
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [7:0] val);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  task automatic program_panels(input logic [7:0] cutoff, input logic [3:0] chain_len,
                                input logic [6:0] p0, input logic [6:0] p1,
                                input logic [6:0] p2, input logic [6:0] p3);
    write_reg(REG_CUTOFF, cutoff);
    write_reg(REG_CHAIN_LEN, 8'(chain_len));
    write_reg(REG_PANEL_0, 8'(p0));
    write_reg(REG_PANEL_1, 8'(p1));
    write_reg(REG_PANEL_2, 8'(p2));
    write_reg(REG_PANEL_3, 8'(p3));
    cur_cutoff = cutoff;
  endtask

  // Random pixel: half of them land on a few hot pixels so that marks are hit again,
  // and colours cluster round the cutoff.
  task automatic random_pixel();
    logic [5:0] x, y;
    logic [7:0] c [3];
    if ($urandom_range(0, 1) == 1) begin
      {x, y} = hot_pixels[$urandom_range(0, 7)];
    end else begin
      x = 6'($urandom);
      y = 6'($urandom);
    end
    for (int k = 0; k < 3; k++) begin
      case ($urandom_range(0, 3))
        0:       c[k] = cur_cutoff - 8'd1;
        1:       c[k] = cur_cutoff;
        default: c[k] = 8'($urandom);
      endcase
    end
    send_pixel(($urandom_range(0, 9) < 3) ? FUNC_SWEEP : FUNC_DRAW, x, y, c[0], c[1], c[2],
               1'($urandom));
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: repeat writes, force, black draws and sweeps on two pixels.
    send_pixel(FUNC_DRAW, 6'd0, 6'd0, 8'd255, 8'd255, 8'd255, 1'b0);
    send_pixel(FUNC_DRAW, 6'd0, 6'd0, 8'd9, 8'd9, 8'd9, 1'b0);
    send_pixel(FUNC_DRAW, 6'd0, 6'd0, 8'd1, 8'd2, 8'd3, 1'b1);
    send_pixel(FUNC_DRAW, 6'd63, 6'd63, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(FUNC_SWEEP, 6'd63, 6'd63, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(FUNC_SWEEP, 6'd63, 6'd63, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(FUNC_SWEEP, 6'd63, 6'd63, 8'd7, 8'd7, 8'd7, 1'b1);
    drain();

    // Every rotation, an order past the chain and dark sweeps.
    program_panels(8'd128, 4'd4, {2'd0, 3'd0, TURN_90}, {2'd1, 3'd3, TURN_180},
                   {2'd2, 3'd7, TURN_270}, {2'd3, 3'd2, TURN_0});
    send_pixel(FUNC_DRAW, 6'd5, 6'd7, 8'd127, 8'd127, 8'd127, 1'b1);
    send_pixel(FUNC_DRAW, 6'd5, 6'd7, 8'd0, 8'd0, 8'd128, 1'b0);
    send_pixel(FUNC_DRAW, 6'd37, 6'd7, 8'd128, 8'd0, 8'd0, 1'b0);
    send_pixel(FUNC_DRAW, 6'd5, 6'd39, 8'd0, 8'd200, 8'd0, 1'b0);
    send_pixel(FUNC_DRAW, 6'd63, 6'd63, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(FUNC_SWEEP, 6'd10, 6'd10, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(FUNC_DRAW, 6'd10, 6'd10, 8'd255, 8'd0, 8'd255, 1'b0);
    send_pixel(FUNC_SWEEP, 6'd10, 6'd10, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(FUNC_DRAW, 6'd31, 6'd31, 8'd170, 8'd85, 8'd240, 1'b0);
    send_pixel(FUNC_DRAW, 6'd32, 6'd32, 8'd15, 8'd129, 8'd0, 1'b0);
    drain();

    // Longest chain, so that the x offset wraps, with the widest parallel offset.
    program_panels(8'd0, 4'd15, {2'd3, 3'd0, TURN_180}, {2'd0, 3'd1, TURN_90},
                   7'h7F, {2'd3, 3'd0, TURN_270});
    send_pixel(FUNC_DRAW, 6'd0, 6'd63, 8'd1, 8'd1, 8'd1, 1'b0);
    send_pixel(FUNC_DRAW, 6'd63, 6'd0, 8'd2, 8'd2, 8'd2, 1'b0);
    send_pixel(FUNC_DRAW, 6'd40, 6'd40, 8'd3, 8'd3, 8'd3, 1'b0);

    // Random phases, each under its own settings, extremes among them.
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: program_panels(8'd0, 4'd1, 7'($urandom), 7'($urandom), 7'($urandom),
                          7'($urandom));
        1: program_panels(8'd255, 4'd15, 7'($urandom), 7'($urandom), 7'($urandom),
                          7'($urandom));
        2: program_panels(8'd128, 4'd0, 7'h7F, 7'h7F, 7'h7F, 7'h7F);
        3: program_panels(8'($urandom), 4'd8, 7'($urandom), 7'($urandom), 7'($urandom),
                          7'($urandom));
        4: program_panels(8'($urandom), 4'($urandom), 7'($urandom), 7'($urandom),
                          7'($urandom), 7'($urandom));
        default: program_panels(8'd1, 4'd2, 7'($urandom), 7'($urandom), 7'($urandom),
                                7'($urandom));
      endcase
      for (int i = 0; i < 8; i++) hot_pixels[i] = 12'($urandom);
      repeat (PHASE_ITEMS) random_pixel();
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("led_panel_grid_pixel_remap_tb: PASS");
    end else begin
      $display("led_panel_grid_pixel_remap_tb: FAIL");
    end
    $finish;
  end

endmodule
